### hw/rtl/cdudc_pkg.sv
`default_nettype none

package cdudc_pkg;

    localparam int YEAR_BITS   = 16;
    localparam int DAY_BITS    = 5;
    localparam int MONTH_BITS  = 4;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int ORDER_BITS  = 2;

    // configuration port
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam logic REG_EPOCH = 1'b0;   // word index, paddr[2]

    typedef logic [YEAR_BITS-1:0]   year_t;
    typedef logic [DAY_BITS-1:0]    day_t;
    typedef logic [MONTH_BITS-1:0]  month_t;
    typedef logic [CMD_BITS-1:0]    cmd_t;
    typedef logic [STATUS_BITS-1:0] status_t;
    typedef logic [ORDER_BITS-1:0]  order_t;

    localparam cmd_t CMD_NEXT = 2'd0;
    localparam cmd_t CMD_PREV = 2'd1;
    localparam cmd_t CMD_SET  = 2'd2;
    localparam cmd_t CMD_CMP  = 2'd3;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_REJECT = 2'd1;
    localparam status_t STATUS_FLOOR  = 2'd2;
    localparam status_t STATUS_LIMIT  = 2'd3;

    localparam order_t ORDER_EQUAL   = 2'd0;
    localparam order_t ORDER_EARLIER = 2'd1;
    localparam order_t ORDER_LATER   = 2'd2;

    localparam year_t  YEAR_MAX    = '1;
    localparam year_t  YEAR_ZERO   = '0;
    localparam year_t  EPOCH_RESET = year_t'(1990);

    localparam day_t   DAY_FIRST = day_t'(1);
    localparam day_t   DAYS_31   = day_t'(31);
    localparam day_t   DAYS_30   = day_t'(30);
    localparam day_t   DAYS_29   = day_t'(29);
    localparam day_t   DAYS_28   = day_t'(28);

    localparam month_t MONTH_JAN = month_t'(1);
    localparam month_t MONTH_FEB = month_t'(2);
    localparam month_t MONTH_APR = month_t'(4);
    localparam month_t MONTH_JUN = month_t'(6);
    localparam month_t MONTH_SEP = month_t'(9);
    localparam month_t MONTH_NOV = month_t'(11);
    localparam month_t MONTH_DEC = month_t'(12);

    // divisibility by 25: y * inv(25) mod 2^16 falls at or below (2^16-1)/25
    localparam year_t DIV25_INV = year_t'(23593);
    localparam year_t DIV25_LIM = year_t'((2**YEAR_BITS - 1) / 25);

    typedef struct packed {
        cmd_t   command;
        day_t   day_in;
        month_t month_in;
        year_t  year_in;
    } req_t;

    typedef struct packed {
        day_t    day_out;
        month_t  month_out;
        year_t   year_out;
        status_t status;
        order_t  order;
    } res_t;

    typedef struct packed {
        day_t   day;
        month_t month;
        year_t  year;
    } date_t;

    // with y a multiple of 4: multiple of 100 iff multiple of 25,
    // multiple of 400 iff also a multiple of 16
    function automatic logic is_leap(year_t y);
        logic [2*YEAR_BITS-1:0] prod;
        logic                   div25;
        prod  = y * DIV25_INV;
        div25 = (prod[YEAR_BITS-1:0] <= DIV25_LIM);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic day_t month_days(month_t m, logic leap);
        day_t d;
        unique case (m)
            MONTH_FEB:                                  d = leap ? DAYS_29 : DAYS_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = DAYS_30;
            default:                                    d = DAYS_31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cdudc_step.sv
`default_nettype none

module cdudc_step (
    input  wire cdudc_pkg::date_t cur,
    input  wire cdudc_pkg::req_t  req,
    input  wire                   req_leap,
    input  wire cdudc_pkg::year_t epoch,
    output cdudc_pkg::date_t      nxt,
    output cdudc_pkg::res_t       res
);
    import cdudc_pkg::*;

    logic    cur_leap;
    day_t    cur_md;
    day_t    prev_md;
    day_t    set_md;
    month_t  prev_month;
    logic    set_ok;
    logic    below;
    status_t status;
    order_t  order;
    logic [DAY_BITS+MONTH_BITS+YEAR_BITS-1:0] key_cur;
    logic [DAY_BITS+MONTH_BITS+YEAR_BITS-1:0] key_req;

    assign cur_leap   = is_leap(cur.year);
    assign cur_md     = month_days(cur.month, cur_leap);
    assign prev_month = month_t'(cur.month - 1'b1);
    assign prev_md    = month_days(prev_month, cur_leap);
    assign set_md     = month_days(req.month_in, req_leap);

    assign set_ok = (req.year_in >= epoch)
                 && (req.month_in >= MONTH_JAN) && (req.month_in <= MONTH_DEC)
                 && (req.day_in >= DAY_FIRST) && (req.day_in <= set_md);

    // year, then month, then day
    assign key_cur = {cur.year, cur.month, cur.day};
    assign key_req = {req.year_in, req.month_in, req.day_in};

    always_comb
    begin
        nxt    = cur;
        status = STATUS_OK;
        order  = ORDER_EQUAL;
        below  = 1'b0;
        unique case (req.command)
            CMD_NEXT:
            begin
                if (cur.day >= cur_md)
                begin
                    if (cur.month >= MONTH_DEC)
                    begin
                        if (cur.year == YEAR_MAX)
                        begin
                            status = STATUS_LIMIT;
                        end
                        else
                        begin
                            nxt.day   = DAY_FIRST;
                            nxt.month = MONTH_JAN;
                            nxt.year  = year_t'(cur.year + 1'b1);
                        end
                    end
                    else
                    begin
                        nxt.day   = DAY_FIRST;
                        nxt.month = month_t'(cur.month + 1'b1);
                    end
                end
                else
                begin
                    nxt.day = day_t'(cur.day + 1'b1);
                end
            end
            CMD_PREV:
            begin
                if (cur.day > DAY_FIRST)
                begin
                    nxt.day = day_t'(cur.day - 1'b1);
                end
                else if (cur.month > MONTH_JAN)
                begin
                    nxt.month = prev_month;
                    nxt.day   = prev_md;
                end
                else if (cur.year == YEAR_ZERO)
                begin
                    below = 1'b1;
                end
                else
                begin
                    nxt.year  = year_t'(cur.year - 1'b1);
                    nxt.month = MONTH_DEC;
                    nxt.day   = DAYS_31;
                end
                // also catches a date left below a raised epoch
                if (below || (nxt.year < epoch))
                begin
                    nxt.day   = DAY_FIRST;
                    nxt.month = MONTH_JAN;
                    nxt.year  = epoch;
                    status    = STATUS_FLOOR;
                end
            end
            CMD_SET:
            begin
                if (set_ok)
                begin
                    nxt.day   = req.day_in;
                    nxt.month = req.month_in;
                    nxt.year  = req.year_in;
                end
                else
                begin
                    status = STATUS_REJECT;
                end
            end
            CMD_CMP:
            begin
                if (key_cur < key_req)
                begin
                    order = ORDER_EARLIER;
                end
                else if (key_cur > key_req)
                begin
                    order = ORDER_LATER;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.day_out   = nxt.day;
        res.month_out = nxt.month;
        res.year_out  = nxt.year;
        res.status    = status;
        res.order     = order;
    end

endmodule

`default_nettype wire

### hw/rtl/calendar_date_up_down_counter_top.sv
// Gregorian date counter: each request carries one command (next day, previous day,
// set date, compare) and returns exactly one result with the stored date after the
// command, a status code and, for compare, the ordering. A request is registered on
// acceptance and executed against the stored date once the result register can take
// it; the stored date is written together with the result register, so a new request
// can be accepted every cycle while the result side does not stall. Request and
// result sides are decoupled by the input and result registers; the request side keeps
// accepting while a result waits, until both registers are full. The epoch year
// (address 0x0, reset 1990) sets the floor date 1 January of that year; change it only
// while no request is in flight.
`default_nettype none

module calendar_date_up_down_counter_top (
    input  wire                              clk,
    input  wire                              rst_n,
    // request channel
    input  wire                              req_valid,
    output logic                             req_ready,
    input  wire cdudc_pkg::req_t             req,
    // result channel
    output logic                             res_valid,
    input  wire                              res_ready,
    output cdudc_pkg::res_t                  res,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [cdudc_pkg::ADDR_BITS-1:0]   paddr,
    input  wire [cdudc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [cdudc_pkg::DATA_BITS-1:0]  prdata,
    output logic                             pready
);
    import cdudc_pkg::*;

    logic  req_fire;
    logic  s1_fire;
    logic  cfg_write;

    logic  s1_valid_reg,  s1_valid_next;
    req_t  req_reg;
    logic  req_leap_reg;
    logic  res_valid_reg, res_valid_next;
    res_t  res_reg;
    date_t cur_reg,       cur_next;
    year_t epoch_reg,     epoch_next;

    date_t step_nxt;
    res_t  step_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[ADDR_BITS-1] == REG_EPOCH)
                     ? DATA_BITS'(epoch_reg) : '0;

    assign s1_fire   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !s1_valid_reg || s1_fire;
    assign req_fire  = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    cdudc_step u_step (
        .cur      (cur_reg),
        .req      (req_reg),
        .req_leap (req_leap_reg),
        .epoch    (epoch_reg),
        .nxt      (step_nxt),
        .res      (step_res)
    );

    always_comb
    begin
        s1_valid_next  = req_fire || (s1_valid_reg && !s1_fire);
        res_valid_next = s1_fire || (res_valid_reg && !res_ready);
        cur_next       = s1_fire ? step_nxt : cur_reg;
        epoch_next     = (cfg_write && (paddr[ADDR_BITS-1] == REG_EPOCH))
                       ? pwdata[YEAR_BITS-1:0] : epoch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            cur_reg       <= '{day: DAY_FIRST, month: MONTH_JAN, year: EPOCH_RESET};
            epoch_reg     <= EPOCH_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            cur_reg       <= cur_next;
            epoch_reg     <= epoch_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg      <= req;
            req_leap_reg <= is_leap(req.year_in);
        end
        if (s1_fire)
        begin
            res_reg <= step_res;
        end
    end

    // stored date is always a real calendar date
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg.month >= MONTH_JAN) && (cur_reg.month <= MONTH_DEC)
        && (cur_reg.day >= DAY_FIRST)
        && (cur_reg.day <= month_days(cur_reg.month, is_leap(cur_reg.year))))
        else $error("stored date out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(cur_reg))
        else $error("date changed without an executed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> res_valid_reg && (res_reg.day_out == cur_reg.day)
                    && (res_reg.month_out == cur_reg.month)
                    && (res_reg.year_out == cur_reg.year))
        else $error("result does not match stored date");

    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> s1_valid_reg && res_valid_reg && !res_ready)
        else $error("request side stalled without backpressure");

endmodule

`default_nettype wire

### sim/calendar_date_up_down_counter_top_tb.sv
module calendar_date_up_down_counter_top_tb;

    import cdudc_pkg::*;

    localparam logic [ADDR_BITS-1:0] EPOCH_ADDR = {REG_EPOCH, 2'b00};
    localparam logic [ADDR_BITS-1:0] SPARE_ADDR = {~REG_EPOCH, 2'b00};

    class date_tracker;
        year_t  floor_year = EPOCH_RESET;
        day_t   held_day   = DAY_FIRST;
        month_t held_month = MONTH_JAN;
        year_t  held_year  = EPOCH_RESET;
        res_t   pending_dates[$];
        int     mismatches = 0;

        function bit leap(year_t y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function day_t days_in(month_t m, year_t y);
            if (m == MONTH_FEB)
                return leap(y) ? DAYS_29 : DAYS_28;
            if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
                return DAYS_30;
            return DAYS_31;
        endfunction

        task report_mismatch(string note);
            mismatches++;
            $display("mismatch: %s", note);
        endtask

        function void apply_command(req_t r);
            res_t want;
            bit   below;
            want.status = STATUS_OK;
            want.order  = ORDER_EQUAL;
            below       = 1'b0;
            case (r.command)
                CMD_NEXT:
                begin
                    if (held_day >= days_in(held_month, held_year))
                    begin
                        if (held_month >= MONTH_DEC)
                        begin
                            if (held_year == YEAR_MAX)
                                want.status = STATUS_LIMIT;
                            else
                            begin
                                held_day   = DAY_FIRST;
                                held_month = MONTH_JAN;
                                held_year  = held_year + 1'b1;
                            end
                        end
                        else
                        begin
                            held_day   = DAY_FIRST;
                            held_month = held_month + 1'b1;
                        end
                    end
                    else
                        held_day = held_day + 1'b1;
                end
                CMD_PREV:
                begin
                    if (held_day > DAY_FIRST)
                        held_day = held_day - 1'b1;
                    else if (held_month > MONTH_JAN)
                    begin
                        held_month = held_month - 1'b1;
                        held_day   = days_in(held_month, held_year);
                    end
                    else if (held_year == YEAR_ZERO)
                        below = 1'b1;
                    else
                    begin
                        held_year  = held_year - 1'b1;
                        held_month = MONTH_DEC;
                        held_day   = DAYS_31;
                    end
                    // also catches a stored date that already sat under a raised epoch
                    if (below || held_year < floor_year)
                    begin
                        held_day    = DAY_FIRST;
                        held_month  = MONTH_JAN;
                        held_year   = floor_year;
                        want.status = STATUS_FLOOR;
                    end
                end
                CMD_SET:
                begin
                    if (r.year_in >= floor_year && r.month_in >= MONTH_JAN &&
                        r.month_in <= MONTH_DEC && r.day_in >= DAY_FIRST &&
                        r.day_in <= days_in(r.month_in, r.year_in))
                    begin
                        held_day   = r.day_in;
                        held_month = r.month_in;
                        held_year  = r.year_in;
                    end
                    else
                        want.status = STATUS_REJECT;
                end
                default:
                begin
                    if ({held_year, held_month, held_day} < {r.year_in, r.month_in, r.day_in})
                        want.order = ORDER_EARLIER;
                    else if ({held_year, held_month, held_day} >
                             {r.year_in, r.month_in, r.day_in})
                        want.order = ORDER_LATER;
                end
            endcase
            want.day_out   = held_day;
            want.month_out = held_month;
            want.year_out  = held_year;
            pending_dates.push_back(want);
        endfunction

        task field_check(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(res_t got);
            res_t want;
            if (pending_dates.size() == 0)
            begin
                report_mismatch($sformatf("result %0d/%0d/%0d with no request pending",
                                          got.day_out, got.month_out, got.year_out));
                return;
            end
            want = pending_dates.pop_front();
            field_check("day_out", got.day_out, want.day_out);
            field_check("month_out", got.month_out, want.month_out);
            field_check("year_out", got.year_out, want.year_out);
            field_check("status", got.status, want.status);
            field_check("order", got.order, want.order);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    res_t                 res;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [DATA_BITS-1:0] pwdata    = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    date_tracker tracker = new();
    int          send_idle_pct = 7;
    int          recv_idle_pct = 58;

    calendar_date_up_down_counter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_200_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                tracker.check_result(res);
            if (req_valid && req_ready)
                tracker.apply_command(req);
        end
    end

    function automatic req_t request_of(cmd_t cmd, int unsigned d, int unsigned m,
                                        int unsigned y);
        req_t r;
        r.command  = cmd;
        r.day_in   = day_t'(d);
        r.month_in = month_t'(m);
        r.year_in  = year_t'(y);
        return r;
    endfunction

    // random data fields ride along on every command
    function automatic req_t random_request(cmd_t cmd);
        req_t r;
        r         = req_t'({$urandom, $urandom});
        r.command = cmd;
        return r;
    endfunction

    // mostly valid dates near the floor, the year limit or century years
    function automatic req_t plausible_date();
        req_t        r;
        int unsigned y;
        day_t        last;
        case ($urandom_range(5))
            0, 1:    y = tracker.floor_year + $urandom_range(3);
            2:       y = YEAR_MAX - $urandom_range(2);
            3:       y = 100 * $urandom_range(16, 24);
            4:       y = tracker.floor_year - 1;
            default: y = $urandom_range(YEAR_MAX);
        endcase
        if (y > YEAR_MAX)
            y = YEAR_MAX;
        r.command  = CMD_SET;
        r.year_in  = year_t'(y);
        r.month_in = month_t'($urandom_range(MONTH_JAN, MONTH_DEC));
        last       = tracker.days_in(r.month_in, r.year_in);
        case ($urandom_range(3))
            0:       r.day_in = last;
            1:       r.day_in = last + 1'b1;
            default: r.day_in = day_t'($urandom_range(DAY_FIRST, last));
        endcase
        return r;
    endfunction

    function automatic req_t nearby_compare();
        req_t r;
        r.command  = CMD_CMP;
        r.day_in   = tracker.held_day;
        r.month_in = tracker.held_month;
        r.year_in  = tracker.held_year;
        case ($urandom_range(3))
            0:       r.day_in   = day_t'(r.day_in + $urandom_range(2) - 1);
            1:       r.month_in = month_t'(r.month_in + $urandom_range(2) - 1);
            2:       r.year_in  = year_t'(r.year_in + $urandom_range(2) - 1);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // one edge first so the last accepted request is already queued
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_dates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic write, input logic [ADDR_BITS-1:0] addr,
                                input logic [DATA_BITS-1:0] data,
                                output logic [DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_epoch_readback();
        logic [DATA_BITS-1:0] rdata;
        apb_transfer(1'b0, EPOCH_ADDR, '0, rdata);
        if (rdata[YEAR_BITS-1:0] !== tracker.floor_year)
            tracker.report_mismatch($sformatf("epoch readback got %0d expected %0d",
                                              rdata[YEAR_BITS-1:0], tracker.floor_year));
    endtask

    // upper write bits are junk on purpose
    task automatic program_epoch(input year_t value);
        logic [DATA_BITS-1:0] unused;
        wait_drained();
        apb_transfer(1'b1, EPOCH_ADDR, DATA_BITS'({$urandom, value}), unused);
        tracker.floor_year = value;
        check_epoch_readback();
    endtask

    task automatic run_random(input int target);
        int sent;
        int pick;
        int burst;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                send_request(plausible_date());
                sent++;
            end
            else if (pick < 65)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                    send_request(random_request(pick < 50 ? CMD_NEXT : CMD_PREV));
                sent += burst;
            end
            else if (pick < 85)
            begin
                send_request(nearby_compare());
                sent++;
            end
            else
            begin
                send_request(random_request(cmd_t'($urandom_range(3))));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [DATA_BITS-1:0] unused;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_epoch(EPOCH_RESET);
        send_request(request_of(CMD_CMP, 1, 1, 1990));
        send_request(request_of(CMD_PREV, 0, 0, 0));
        send_request(request_of(CMD_SET, 31, 12, 1999));
        send_request(request_of(CMD_NEXT, 31, 15, 65535));
        send_request(request_of(CMD_SET, 28, 2, 2000));
        send_request(request_of(CMD_NEXT, 0, 0, 0));
        send_request(request_of(CMD_NEXT, 0, 0, 0));
        send_request(request_of(CMD_PREV, 0, 0, 0));
        send_request(request_of(CMD_SET, 29, 2, 2001));
        send_request(request_of(CMD_SET, 30, 4, 2020));
        send_request(request_of(CMD_NEXT, 0, 0, 0));
        send_request(request_of(CMD_SET, 31, 4, 2020));
        send_request(request_of(CMD_SET, 0, 5, 2020));
        send_request(request_of(CMD_SET, 10, 0, 2020));
        send_request(request_of(CMD_SET, 31, 15, 65535));
        send_request(request_of(CMD_SET, 1, 1, 1989));
        send_request(request_of(CMD_SET, 31, 12, 65535));
        send_request(request_of(CMD_NEXT, 0, 0, 0));
        send_request(request_of(CMD_CMP, 31, 15, 65535));
        send_request(request_of(CMD_CMP, 1, 1, 0));

        program_epoch(YEAR_ZERO);
        send_request(request_of(CMD_SET, 28, 2, 1900));
        send_request(request_of(CMD_NEXT, 0, 0, 0));
        send_request(request_of(CMD_SET, 1, 1, 0));
        send_request(request_of(CMD_PREV, 0, 0, 0));
        send_request(request_of(CMD_SET, 1, 6, 2000));

        // epoch raised past the stored date
        program_epoch(year_t'(2500));
        send_request(request_of(CMD_PREV, 0, 0, 0));
        program_epoch(YEAR_ZERO);
        send_request(request_of(CMD_SET, 10, 6, 2000));
        program_epoch(year_t'(2500));
        send_request(request_of(CMD_NEXT, 0, 0, 0));
        send_request(request_of(CMD_CMP, 11, 6, 2000));

        // writes to the unused word must leave the epoch alone
        wait_drained();
        apb_transfer(1'b1, SPARE_ADDR, $urandom, unused);
        check_epoch_readback();

        program_epoch(EPOCH_RESET);
        run_random(85);
        program_epoch(YEAR_ZERO);
        run_random(85);

        send_idle_pct = 58;
        recv_idle_pct = 7;
        program_epoch(YEAR_MAX);
        run_random(80);
        program_epoch(year_t'($urandom_range(YEAR_MAX)));
        run_random(85);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_epoch(year_t'($urandom_range(1580, 2420)));
        run_random(85);
        program_epoch(year_t'($urandom));
        run_random(85);

        wait_drained();
        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cdudc_pkg.sv
hw/rtl/cdudc_step.sv
hw/rtl/calendar_date_up_down_counter_top.sv
sim/calendar_date_up_down_counter_top_tb.sv
